[design/sbe_pkg.sv]
// Package for the stack bytecode executor: field widths, default sizes,
// command, status and opcode codes, and the controller/datapath interface types.
// Depends on nothing; the top level, controller and datapath refer to it by scoped names.
package sbe_pkg;

    // Default sizes of the stores.
    localparam int CODE_DEPTH_DEF       = 1024;
    localparam int STACK_DEPTH_DEF      = 256;
    localparam int MAX_FRAMES_DEF       = 16;
    localparam int LOCALS_PER_FRAME_DEF = 16;
    localparam int GLOBAL_COUNT_DEF     = 64;

    // Field widths.
    localparam int CFG_W     = 11;
    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 10;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int PC_W      = 10;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [CFG_W-1:0] CODE_LENGTH_RST = 11'd1024;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRINTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXITED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_OP  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd7;

    // Opcodes.
    localparam logic [4:0] OP_PUSH   = 5'd0;
    localparam logic [4:0] OP_POP    = 5'd1;
    localparam logic [4:0] OP_STORE  = 5'd2;
    localparam logic [4:0] OP_LOAD   = 5'd3;
    localparam logic [4:0] OP_GSTORE = 5'd4;
    localparam logic [4:0] OP_GLOAD  = 5'd5;
    localparam logic [4:0] OP_ADD    = 5'd6;
    localparam logic [4:0] OP_SUB    = 5'd7;
    localparam logic [4:0] OP_MUL    = 5'd8;
    localparam logic [4:0] OP_DIV    = 5'd9;
    localparam logic [4:0] OP_MOD    = 5'd10;
    localparam logic [4:0] OP_EQ     = 5'd11;
    localparam logic [4:0] OP_NEQ    = 5'd12;
    localparam logic [4:0] OP_LT     = 5'd13;
    localparam logic [4:0] OP_GT     = 5'd14;
    localparam logic [4:0] OP_LTE    = 5'd15;
    localparam logic [4:0] OP_GTE    = 5'd16;
    localparam logic [4:0] OP_NOT    = 5'd17;
    localparam logic [4:0] OP_AND    = 5'd18;
    localparam logic [4:0] OP_OR     = 5'd19;
    localparam logic [4:0] OP_PRINT  = 5'd20;
    localparam logic [4:0] OP_BRF    = 5'd21;
    localparam logic [4:0] OP_BR     = 5'd22;
    localparam logic [4:0] OP_NOOP   = 5'd23;
    localparam logic [4:0] OP_CALL   = 5'd24;
    localparam logic [4:0] OP_RET    = 5'd25;
    localparam logic [4:0] OP_EXIT   = 5'd26;
    localparam logic [WORD_W-1:0] OP_LAST = 32'd26;

    // Where the controller goes next.
    typedef enum logic [2:0] {
        ROUTE_DONE,
        ROUTE_START,
        ROUTE_FETCH,
        ROUTE_DIV,
        ROUTE_COPY
    } route_t;

    // Phase commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic start;
        logic fetch;
        logic opnd1;
        logic exec;
        logic div;
        logic copy_rd;
        logic copy_wr;
        logic emit;
    } sbe_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        route_t take_route;
        route_t exec_route;
        logic   div_done;
        logic   copy_last;
    } sbe_sts_t;

endpackage

[design/stack_bytecode_executor_core.sv]
// Top level of the stack bytecode executor: controller and datapath.
// Depends on sbe_pkg, sbe_ctrl and sbe_dpath.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_tvalid / s_tready    request: cmd, code_address, code_word
//  m_        out        m_tvalid / m_tready    result: status, print_value, counter
//  cfg_      in         cfg_valid / cfg_ready  code_length
//
// Code write requests go from IDLE to DONE, start requests through START, and executes that run
// go through FETCH, OPND1 and EXEC; DIV and MOD then wait on the one-bit-per-cycle divider,
// and CALL copies each parameter from the stack RAM into the local RAM (one port each).
// Reset is synchronous and active low; it clears the machine registers and the
// local valid bits, and no memory clearing pass is needed.
// A new request is taken while a result still waits in the output register.
module stack_bytecode_executor_core #(
    parameter int CODE_DEPTH       = sbe_pkg::CODE_DEPTH_DEF,
    parameter int STACK_DEPTH      = sbe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_FRAMES       = sbe_pkg::MAX_FRAMES_DEF,
    parameter int LOCALS_PER_FRAME = sbe_pkg::LOCALS_PER_FRAME_DEF,
    parameter int GLOBAL_COUNT     = sbe_pkg::GLOBAL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], code_address[11:2], code_word[43:12], zeros above
    input  logic [sbe_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], print_value[34:3], program_counter[44:35], zeros above
    output logic [sbe_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbe_pkg::CFG_W-1:0]     cfg_data
);

    sbe_pkg::sbe_ctl_t ctl;
    sbe_pkg::sbe_sts_t sts;

    assign cfg_ready = 1'b1;

    sbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    sbe_dpath #(
        .CODE_DEPTH       (CODE_DEPTH),
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_FRAMES       (MAX_FRAMES),
        .LOCALS_PER_FRAME (LOCALS_PER_FRAME),
        .GLOBAL_COUNT     (GLOBAL_COUNT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

[design/sbe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/sbe_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing; used by the executor datapath for DIV and MOD.
module sbe_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] ub_reg, ub_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, ub_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ub_next   = ub_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            ub_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            negq_next = dividend[31] ^ divisor[31];
            negr_next = dividend[31];
        end else if (busy_reg) begin
            // Restoring step: keep the trial difference when it does not go negative.
            rem_next = trial[32] ? shifted[31:0] : trial[31:0];
            quo_next = {quo_reg[30:0], ~trial[32]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        ub_reg   <= ub_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done      = done_reg;
    assign quotient  = negq_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = negr_reg ? (32'd0 - rem_reg) : rem_reg;

endmodule

[design/sbe_ctrl.sv]
// Controller state machine of the stack bytecode executor: request and result
// handshakes and the phase sequence. Depends on sbe_pkg.
module sbe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  sbe_pkg::sbe_sts_t sts,
    output sbe_pkg::sbe_ctl_t ctl
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_START   = 9'b000000010,
        S_FETCH   = 9'b000000100,
        S_OPND1   = 9'b000001000,
        S_EXEC    = 9'b000010000,
        S_DIV     = 9'b000100000,
        S_COPY_RD = 9'b001000000,
        S_COPY_WR = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.take = 1'b1;
                    unique case (sts.take_route)
                        sbe_pkg::ROUTE_START: state_next = S_START;
                        sbe_pkg::ROUTE_FETCH: state_next = S_FETCH;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_START: begin
                ctl.start  = 1'b1;
                state_next = S_DONE;
            end
            S_FETCH: begin
                ctl.fetch  = 1'b1;
                state_next = S_OPND1;
            end
            S_OPND1: begin
                ctl.opnd1  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                ctl.exec = 1'b1;
                unique case (sts.exec_route)
                    sbe_pkg::ROUTE_DIV:  state_next = S_DIV;
                    sbe_pkg::ROUTE_COPY: state_next = S_COPY_RD;
                    default:             state_next = S_DONE;
                endcase
            end
            S_DIV: begin
                ctl.div = 1'b1;
                if (sts.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_COPY_RD: begin
                ctl.copy_rd = 1'b1;
                state_next  = S_COPY_WR;
            end
            S_COPY_WR: begin
                ctl.copy_wr = 1'b1;
                state_next  = sts.copy_last ? S_DONE : S_COPY_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    ctl.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[design/sbe_dpath.sv]
// Datapath of the stack bytecode executor: code, stack, local and global
// memories, machine registers, ALU, divider and result register.
// Depends on sbe_pkg, sbe_ram and sbe_div.
module sbe_dpath #(
    parameter int CODE_DEPTH       = sbe_pkg::CODE_DEPTH_DEF,
    parameter int STACK_DEPTH      = sbe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_FRAMES       = sbe_pkg::MAX_FRAMES_DEF,
    parameter int LOCALS_PER_FRAME = sbe_pkg::LOCALS_PER_FRAME_DEF,
    parameter int GLOBAL_COUNT     = sbe_pkg::GLOBAL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sbe_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [sbe_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    input  logic [sbe_pkg::CFG_W-1:0]     cfg_data,
    input  sbe_pkg::sbe_ctl_t             ctl,
    output sbe_pkg::sbe_sts_t             sts
);

    localparam int CAW       = $clog2(CODE_DEPTH);
    localparam int IPW       = $clog2(CODE_DEPTH + 1);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int FDW       = $clog2(MAX_FRAMES);
    localparam int LOC_DEPTH = MAX_FRAMES * LOCALS_PER_FRAME;
    localparam int LAW       = $clog2(LOC_DEPTH);
    localparam int LIW       = $clog2(LOCALS_PER_FRAME);
    localparam int LCW       = $clog2(LOCALS_PER_FRAME + 1);
    localparam int GAW       = $clog2(GLOBAL_COUNT);
    // Floor reciprocal for the code address modulo; one correction suffices.
    localparam int unsigned RECIP = (1 << 20) / CODE_DEPTH;
    localparam int PAD_W = sbe_pkg::M_TDATA_W - sbe_pkg::STATUS_W - sbe_pkg::WORD_W
                           - sbe_pkg::PC_W;

    // Request fields.
    logic [sbe_pkg::CMD_W-1:0]  req_cmd;
    logic [sbe_pkg::ADDR_W-1:0] req_addr;
    logic [31:0]                req_word;

    assign req_cmd  = s_tdata[1:0];
    assign req_addr = s_tdata[11:2];
    assign req_word = s_tdata[43:12];

    // Machine state.
    logic [IPW-1:0]       ip_reg, ip_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic [FDW-1:0]       fd_reg, fd_next;
    logic                 run_reg, run_next;
    logic [sbe_pkg::CFG_W-1:0] clen_reg;
    logic [LOC_DEPTH-1:0] lvalid_reg, lvalid_next;
    logic [IPW-1:0]       ras_reg [MAX_FRAMES];

    // Per-instruction working registers.
    logic [4:0]  op_reg;
    logic        op_bad_reg;
    logic [31:0] w1_reg;
    logic [31:0] a_reg;
    logic        lv_reg;
    logic [LCW-1:0] cnt_reg, cnt_next;
    logic [LCW-1:0] n_reg, n_next;
    logic [sbe_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [31:0] res_print_reg, res_print_next;
    logic [sbe_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Memory ports.
    logic            code_we;
    logic [CAW-1:0]  code_waddr, code_raddr;
    logic [31:0]     code_rdata;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [31:0]     stk_wdata, stk_rdata;
    logic            loc_we;
    logic [LAW-1:0]  loc_waddr, loc_raddr;
    logic [31:0]     loc_wdata, loc_rdata;
    logic            glb_we;
    logic [GAW-1:0]  glb_raddr;
    logic [31:0]     glb_rdata;

    logic        div_start, div_done;
    logic [31:0] div_quo, div_rem;

    // Helper signals.
    logic [31:0] ip32, sp32, lim32, clen32;
    logic [31:0] mod_prod, mod_rem;
    logic [31:0] b_val, ld_val, alu_r, n32;
    logic [31:0] nops;
    logic [FDW:0] nd_wide;
    logic [FDW-1:0] nd;
    logic        clr_en, lv_set, commit_call;
    logic [FDW-1:0] clr_row;
    logic [LAW-1:0] lv_addr;
    logic [LCW-1:0] call_n;
    sbe_pkg::route_t take_route, exec_route;

    function automatic logic [IPW-1:0] target_of(input logic [31:0] w);
        return (w >= 32'(CODE_DEPTH)) ? IPW'(CODE_DEPTH) : w[IPW-1:0];
    endfunction

    function automatic logic [LAW-1:0] loc_addr(input logic [FDW-1:0] row,
                                                 input logic [LIW-1:0] idx);
        return LAW'(row) * LAW'(LOCALS_PER_FRAME) + LAW'(idx);
    endfunction

    assign ip32   = 32'(ip_reg);
    assign sp32   = 32'(sp_reg);
    assign clen32 = 32'(clen_reg);
    assign lim32  = (clen32 > 32'(CODE_DEPTH)) ? 32'(CODE_DEPTH) : clen32;

    // Code write address modulo the code depth.
    assign mod_prod   = 32'(req_addr) * 32'(RECIP);
    assign mod_rem    = 32'(req_addr) - 32'(mod_prod[31:20]) * 32'(CODE_DEPTH);
    assign code_waddr = (mod_rem >= 32'(CODE_DEPTH)) ? CAW'(mod_rem - 32'(CODE_DEPTH))
                                                     : CAW'(mod_rem);

    assign b_val   = stk_rdata;
    assign ld_val  = lv_reg ? loc_rdata : 32'd0;
    assign n32     = code_rdata[31] ? 32'd0 : code_rdata;
    assign nd_wide = {1'b0, fd_reg} + (FDW+1)'(1);
    assign nd      = nd_wide[FDW-1:0];
    assign nops    = (op_reg <= sbe_pkg::OP_GLOAD || op_reg == sbe_pkg::OP_BRF
                      || op_reg == sbe_pkg::OP_BR) ? 32'd1
                   : (op_reg == sbe_pkg::OP_CALL) ? 32'd2 : 32'd0;

    // ALU for the two-operand instructions other than DIV and MOD.
    always_comb begin
        case (op_reg)
            sbe_pkg::OP_ADD: alu_r = a_reg + b_val;
            sbe_pkg::OP_SUB: alu_r = a_reg - b_val;
            sbe_pkg::OP_MUL: alu_r = a_reg * b_val;
            sbe_pkg::OP_EQ:  alu_r = 32'(a_reg == b_val);
            sbe_pkg::OP_NEQ: alu_r = 32'(a_reg != b_val);
            sbe_pkg::OP_LT:  alu_r = 32'($signed(a_reg) < $signed(b_val));
            sbe_pkg::OP_GT:  alu_r = 32'($signed(a_reg) > $signed(b_val));
            sbe_pkg::OP_LTE: alu_r = 32'($signed(a_reg) <= $signed(b_val));
            sbe_pkg::OP_GTE: alu_r = 32'($signed(a_reg) >= $signed(b_val));
            sbe_pkg::OP_AND: alu_r = a_reg & b_val;
            default:         alu_r = a_reg | b_val;
        endcase
    end

    // Read addresses, by phase.
    always_comb begin
        code_raddr = (req_cmd == sbe_pkg::CMD_START) ? '0 : CAW'(ip_reg);
        stk_raddr  = SAW'(sp32 - 32'd1);
        if (ctl.fetch) begin
            code_raddr = CAW'(ip32 + 32'd1);
        end else if (ctl.opnd1) begin
            code_raddr = CAW'(ip32 + 32'd2);
            stk_raddr  = SAW'(sp32 - 32'd2);
        end else if (ctl.copy_rd) begin
            stk_raddr  = SAW'(sp32 - 32'(cnt_reg) - 32'd1);
        end
        loc_raddr = loc_addr(fd_reg, code_rdata[LIW-1:0]);
        glb_raddr = GAW'(code_rdata);
    end

    always_comb begin
        if (req_cmd == sbe_pkg::CMD_WRITE) begin
            take_route = sbe_pkg::ROUTE_DONE;
        end else if (req_cmd == sbe_pkg::CMD_START) begin
            take_route = sbe_pkg::ROUTE_START;
        end else if (req_cmd == sbe_pkg::CMD_EXEC && run_reg && ip32 < lim32) begin
            take_route = sbe_pkg::ROUTE_FETCH;
        end else begin
            take_route = sbe_pkg::ROUTE_DONE;
        end
    end

    // Main next-state logic.
    always_comb begin
        ip_next         = ip_reg;
        sp_next         = sp_reg;
        fd_next         = fd_reg;
        run_next        = run_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_print_next  = res_print_reg;
        exec_route      = sbe_pkg::ROUTE_DONE;
        code_we         = 1'b0;
        stk_we          = 1'b0;
        stk_waddr       = SAW'(sp_reg);
        stk_wdata       = 32'd0;
        loc_we          = 1'b0;
        loc_waddr       = loc_addr(fd_reg, w1_reg[LIW-1:0]);
        loc_wdata       = a_reg;
        glb_we          = 1'b0;
        div_start       = 1'b0;
        clr_en          = 1'b0;
        clr_row         = nd;
        lv_set          = 1'b0;
        lv_addr         = loc_waddr;
        commit_call     = 1'b0;
        call_n          = n_reg;

        if (ctl.take) begin
            res_print_next  = 32'd0;
            res_status_next = sbe_pkg::ST_OK;
            if (req_cmd == sbe_pkg::CMD_WRITE) begin
                code_we = 1'b1;
            end else if (req_cmd == sbe_pkg::CMD_EXEC && run_reg) begin
                if (ip32 >= lim32) begin
                    res_status_next = sbe_pkg::ST_END;
                    run_next        = 1'b0;
                end
            end else if (req_cmd != sbe_pkg::CMD_START) begin
                res_status_next = sbe_pkg::ST_IDLE;
            end
        end

        if (ctl.start) begin
            ip_next  = target_of(code_rdata);
            sp_next  = '0;
            fd_next  = '0;
            run_next = 1'b1;
            clr_en   = 1'b1;
            clr_row  = '0;
        end

        if (ctl.exec) begin
            if (op_bad_reg) begin
                res_status_next = sbe_pkg::ST_BAD_OP;
                run_next        = 1'b0;
            end else if (ip32 + nops >= lim32) begin
                res_status_next = sbe_pkg::ST_END;
                run_next        = 1'b0;
            end else begin
                res_status_next = sbe_pkg::ST_FAULT;
                unique case (op_reg) inside
                    sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD, sbe_pkg::OP_GLOAD: begin
                        if (sp32 < 32'(STACK_DEPTH)
                            && (op_reg == sbe_pkg::OP_PUSH
                                || (op_reg == sbe_pkg::OP_LOAD
                                    && w1_reg < 32'(LOCALS_PER_FRAME))
                                || (op_reg == sbe_pkg::OP_GLOAD
                                    && w1_reg < 32'(GLOBAL_COUNT)))) begin
                            stk_we          = 1'b1;
                            stk_wdata       = (op_reg == sbe_pkg::OP_PUSH) ? w1_reg
                                            : (op_reg == sbe_pkg::OP_LOAD) ? ld_val
                                            : glb_rdata;
                            sp_next         = sp_reg + SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd2);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_POP: begin
                        if (sp32 >= 32'd1) begin
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd1);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_STORE: begin
                        if (sp32 >= 32'd1 && w1_reg < 32'(LOCALS_PER_FRAME)) begin
                            loc_we          = 1'b1;
                            lv_set          = 1'b1;
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd2);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_GSTORE: begin
                        if (sp32 >= 32'd1 && w1_reg < 32'(GLOBAL_COUNT)) begin
                            glb_we          = 1'b1;
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd2);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_NOT: begin
                        if (sp32 >= 32'd1) begin
                            stk_we          = 1'b1;
                            stk_waddr       = SAW'(sp32 - 32'd1);
                            stk_wdata       = 32'(a_reg == 32'd0);
                            ip_next         = IPW'(ip32 + 32'd1);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_PRINT: begin
                        if (sp32 >= 32'd1) begin
                            res_print_next  = a_reg;
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd1);
                            res_status_next = sbe_pkg::ST_PRINTED;
                        end
                    end
                    sbe_pkg::OP_BRF: begin
                        if (sp32 >= 32'd1) begin
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = (a_reg == 32'd0) ? target_of(w1_reg)
                                                               : IPW'(ip32 + 32'd2);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_BR: begin
                        ip_next         = target_of(w1_reg);
                        res_status_next = sbe_pkg::ST_OK;
                    end
                    sbe_pkg::OP_NOOP: begin
                        ip_next         = IPW'(ip32 + 32'd2);
                        res_status_next = sbe_pkg::ST_OK;
                    end
                    sbe_pkg::OP_CALL: begin
                        // The word after the target is the parameter count.
                        if (32'(nd_wide) < 32'(MAX_FRAMES)
                            && n32 <= 32'(LOCALS_PER_FRAME) && n32 <= sp32) begin
                            res_status_next = sbe_pkg::ST_OK;
                            clr_en          = 1'b1;
                            n_next          = LCW'(n32);
                            cnt_next        = '0;
                            call_n          = LCW'(n32);
                            if (n32 == 32'd0) begin
                                commit_call = 1'b1;
                            end else begin
                                exec_route = sbe_pkg::ROUTE_COPY;
                            end
                        end
                    end
                    sbe_pkg::OP_RET: begin
                        if (fd_reg != '0) begin
                            ip_next         = ras_reg[fd_reg];
                            fd_next         = fd_reg - FDW'(1);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                    sbe_pkg::OP_EXIT: begin
                        ip_next         = IPW'(ip32 + 32'd1);
                        run_next        = 1'b0;
                        res_status_next = sbe_pkg::ST_EXITED;
                    end
                    sbe_pkg::OP_DIV, sbe_pkg::OP_MOD: begin
                        if (sp32 >= 32'd2) begin
                            if (b_val == 32'd0) begin
                                res_status_next = sbe_pkg::ST_DIVZ;
                            end else begin
                                res_status_next = sbe_pkg::ST_OK;
                                div_start       = 1'b1;
                                exec_route      = sbe_pkg::ROUTE_DIV;
                            end
                        end
                    end
                    default: begin
                        if (sp32 >= 32'd2) begin
                            stk_we          = 1'b1;
                            stk_waddr       = SAW'(sp32 - 32'd2);
                            stk_wdata       = alu_r;
                            sp_next         = sp_reg - SPW'(1);
                            ip_next         = IPW'(ip32 + 32'd1);
                            res_status_next = sbe_pkg::ST_OK;
                        end
                    end
                endcase
                if (res_status_next == sbe_pkg::ST_FAULT
                    || res_status_next == sbe_pkg::ST_DIVZ) begin
                    run_next = 1'b0;
                end
            end
        end

        if (ctl.div && div_done) begin
            stk_we    = 1'b1;
            stk_waddr = SAW'(sp32 - 32'd2);
            stk_wdata = (op_reg == sbe_pkg::OP_MOD) ? div_rem : div_quo;
            sp_next   = sp_reg - SPW'(1);
            ip_next   = IPW'(ip32 + 32'd1);
        end

        if (ctl.copy_wr) begin
            loc_we    = 1'b1;
            loc_waddr = loc_addr(nd, cnt_reg[LIW-1:0]);
            loc_wdata = stk_rdata;
            lv_set    = 1'b1;
            lv_addr   = loc_waddr;
            cnt_next  = cnt_reg + LCW'(1);
            if (cnt_reg + LCW'(1) == n_reg) begin
                commit_call = 1'b1;
            end
        end

        if (commit_call) begin
            sp_next = SPW'(sp32 - 32'(call_n));
            fd_next = nd;
            ip_next = target_of(w1_reg);
        end
    end

    // Local valid bits: a frame row is cleared on start and on call.
    always_comb begin
        lvalid_next = lvalid_reg;
        for (int f = 0; f < MAX_FRAMES; f++) begin
            for (int i = 0; i < LOCALS_PER_FRAME; i++) begin
                if (clr_en && clr_row == FDW'(f)) begin
                    lvalid_next[f * LOCALS_PER_FRAME + i] = 1'b0;
                end
            end
        end
        if (lv_set) begin
            lvalid_next[lv_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg     <= '0;
            sp_reg     <= '0;
            fd_reg     <= '0;
            run_reg    <= 1'b0;
            clen_reg   <= sbe_pkg::CODE_LENGTH_RST;
            lvalid_reg <= '0;
            cnt_reg    <= '0;
            n_reg      <= '0;
        end else begin
            ip_reg     <= ip_next;
            sp_reg     <= sp_next;
            fd_reg     <= fd_next;
            run_reg    <= run_next;
            lvalid_reg <= lvalid_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            if (cfg_valid) begin
                clen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_print_reg  <= res_print_next;
        if (ctl.fetch) begin
            op_reg     <= code_rdata[4:0];
            op_bad_reg <= code_rdata > sbe_pkg::OP_LAST;
        end
        if (ctl.opnd1) begin
            w1_reg <= code_rdata;
            a_reg  <= stk_rdata;
            lv_reg <= lvalid_reg[loc_raddr];
        end
        if (commit_call) begin
            ras_reg[nd] <= IPW'(ip32 + 32'd3);
        end
        if (ctl.emit) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, sbe_pkg::PC_W'(ip_reg), res_print_reg,
                            res_status_reg};
        end
    end

    sbe_ram #(.WIDTH(32), .DEPTH(CODE_DEPTH)) u_code_ram (
        .aclk  (aclk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (req_word),
        .raddr (code_raddr),
        .rdata (code_rdata)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(LOC_DEPTH)) u_local_ram (
        .aclk  (aclk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (loc_raddr),
        .rdata (loc_rdata)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(GLOBAL_COUNT)) u_global_ram (
        .aclk  (aclk),
        .we    (glb_we),
        .waddr (GAW'(w1_reg)),
        .wdata (a_reg),
        .raddr (glb_raddr),
        .rdata (glb_rdata)
    );

    sbe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_val),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sts.take_route = take_route;
    assign sts.exec_route = exec_route;
    assign sts.div_done   = div_done;
    assign sts.copy_last  = (cnt_reg + LCW'(1) == n_reg);
    assign m_tdata        = m_tdata_reg;

endmodule
